/* hdl/pmsp_pkg.sv */
// Package for the PIM mode switch policy block.
// Holds sizes, action and register codes, and the controller/datapath structs.
// No dependencies.
package pmsp_pkg;

  localparam int NUM_BANKS = 16;
  localparam int BIDX_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int BANK_W = 4;
  localparam int ROW_W = 16;
  localparam int CYC_W = 32;
  localparam int DIV_W = 40;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_BANK = 2'd1;
  localparam logic [1:0] ACT_PIM = 2'd2;

  localparam logic [1:0] REG_WRITE_QUEUE_ON = 2'd0;
  localparam logic [1:0] REG_DEFAULT_LATENCY = 2'd1;
  localparam logic [1:0] REG_MAX_SLOWDOWN = 2'd2;

  typedef struct packed {
    logic cap;
    logic bank_upd;
    logic pim_upd;
    logic set_len;
    logic set_prod;
    logic widx_inc;
    logic scan;
    logic go_pim;
    logic go_normal;
    logic div_start;
    logic div_sel;
    logic avg_dflt;
    logic avg_from_div;
    logic bud_write;
    logic out_load;
  } pmsp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic mode;
    logic over;
    logic pim;
    logic normal_waiting;
    logic cnt_zero;
    logic avg_zero;
    logic div_done;
    logic exceeded;
    logic last;
    logic out_free;
  } pmsp_sts_t;

endpackage

/* hdl/pmsp_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pmsp_pkg for its widths.
module pmsp_div
  import pmsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [31:0]      divisor,
  output logic [DIV_W-1:0] quot,
  output logic             done
);

  logic [31:0]          rem;
  logic [31:0]          dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [32:0]          trial;
  logic                 fits;

  assign trial = {rem, quot[DIV_W-1]};
  assign fits = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= DIV_CNT_W'(DIV_W);
      end else if (running) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quot <= dividend;
    end else if (running) begin
      rem <= fits ? 32'(trial - {1'b0, dsr}) : trial[31:0];
      quot <= {quot[DIV_W-2:0], fits};
    end
  end

endmodule

/* hdl/pmsp_dp.sv */
// Datapath of the PIM mode switch policy: per-bank statistics, batch state,
// budget arithmetic and the result register. Depends on pmsp_pkg and pmsp_div.
module pmsp_dp
  import pmsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  pmsp_cmd_t   cmd,
  output pmsp_sts_t   sts,
  input  logic [1:0]  in_action,
  input  logic [71:0] in_data,
  input  logic        write_queue_on,
  input  logic [7:0]  default_latency,
  input  logic [7:0]  max_slowdown,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data
);

  // Captured item.
  logic [1:0]        act;
  logic [CYC_W-1:0]  cyc;
  logic              rd, wr, pim, gnt;
  logic [ROW_W-1:0]  frow, grow;
  logic [BANK_W-1:0] bnk;

  logic [31:0] req_count [NUM_BANKS];
  logic [31:0] req_budget [NUM_BANKS];
  logic [31:0] req_start [NUM_BANKS];
  logic [31:0] busy_time [NUM_BANKS];
  logic [ROW_W-1:0] last_row;
  logic [31:0] batch_start, batch_length;
  logic mode;
  logic [31:0] switch_to_normal, switch_to_pim;

  logic [BIDX_W-1:0] widx, ridx;
  logic              exc;
  logic [DIV_W-1:0]  prod;
  logic [31:0]       avg;
  logic              r_to_pim, r_to_normal;

  logic [31:0]      cur_cnt, cur_bud, cur_start, cur_busy;
  logic             bank_ok, cmp;
  logic [7:0]       factor;
  logic [DIV_W-1:0] dvd, quot;
  logic [31:0]      dsr;
  logic             div_done, sat;

  assign bank_ok = 32'(bnk) < 32'(NUM_BANKS);
  assign ridx = (act == ACT_BANK) ? BIDX_W'(bnk) : widx;
  assign cur_cnt = req_count[ridx];
  assign cur_bud = req_budget[ridx];
  assign cur_start = req_start[ridx];
  assign cur_busy = busy_time[ridx];
  assign cmp = cur_cnt > cur_bud;
  assign factor = (max_slowdown == 8'd0) ? 8'd0 : max_slowdown - 8'd1;
  assign dvd = cmd.div_sel ? prod : DIV_W'(cur_busy);
  assign dsr = cmd.div_sel ? avg : cur_cnt;
  assign sat = (avg == 32'd0) || (quot[DIV_W-1:32] != '0);

  pmsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .quot     (quot),
    .done     (div_done)
  );

  always_comb begin
    sts.action = act;
    sts.mode = mode;
    sts.over = (batch_start != 32'd0) && (!pim || frow != last_row);
    sts.pim = pim;
    sts.normal_waiting = rd || (wr && write_queue_on);
    sts.cnt_zero = cur_cnt == 32'd0;
    sts.avg_zero = avg == 32'd0;
    sts.div_done = div_done;
    sts.exceeded = exc || cmp;
    sts.last = widx == BIDX_W'(NUM_BANKS - 1);
    sts.out_free = !out_valid || out_ready;
  end

  // Item capture and working registers.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      act <= in_action;
      cyc <= in_data[31:0];
      rd <= in_data[32];
      wr <= in_data[33];
      pim <= in_data[34];
      frow <= in_data[50:35];
      bnk <= in_data[54:51];
      gnt <= in_data[55];
      grow <= in_data[71:56];
    end
    // The product needs the full 40 bits, so both operands are widened first.
    if (cmd.set_prod) prod <= DIV_W'(batch_length) * DIV_W'(factor);
    if (cmd.avg_dflt) avg <= 32'(default_latency);
    else if (cmd.avg_from_div) avg <= quot[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        req_count[i] <= '0;
        req_budget[i] <= '0;
        req_start[i] <= '0;
        busy_time[i] <= '0;
      end
      last_row <= '0;
      batch_start <= '0;
      batch_length <= '0;
      mode <= 1'b0;
      switch_to_normal <= '0;
      switch_to_pim <= '0;
      widx <= '0;
      exc <= 1'b0;
      r_to_pim <= 1'b0;
      r_to_normal <= 1'b0;
      out_valid <= 1'b0;
      out_data <= '0;
    end else begin
      if (cmd.cap) begin
        widx <= '0;
        exc <= 1'b0;
        r_to_pim <= 1'b0;
        r_to_normal <= 1'b0;
      end else if (cmd.widx_inc) begin
        widx <= widx + BIDX_W'(1);
      end
      if (cmd.scan && cmp) exc <= 1'b1;
      if (cmd.bank_upd && bank_ok) begin
        if (cur_start != 32'd0) begin
          busy_time[ridx] <= cur_busy + (cyc - cur_start);
          req_count[ridx] <= cur_cnt + 32'd1;
        end
        req_start[ridx] <= gnt ? cyc : 32'd0;
      end
      if (cmd.pim_upd && gnt) begin
        if (batch_start == 32'd0) batch_start <= cyc;
        last_row <= grow;
      end
      if (cmd.set_len) batch_length <= cyc - batch_start;
      if (cmd.bud_write) req_budget[widx] <= sat ? '1 : quot[31:0];
      if (cmd.go_pim) begin
        mode <= 1'b1;
        switch_to_pim <= switch_to_pim + 32'd1;
        r_to_pim <= 1'b1;
      end
      if (cmd.go_normal) begin
        for (int i = 0; i < NUM_BANKS; i++) begin
          req_count[i] <= '0;
          req_start[i] <= '0;
          busy_time[i] <= '0;
        end
        batch_start <= '0;
        mode <= 1'b0;
        switch_to_normal <= switch_to_normal + 32'd1;
        r_to_normal <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        out_data <= {5'd0, r_to_normal, r_to_pim, mode};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/pmsp_ctrl.sv */
// Controller state machine of the PIM mode switch policy.
// Sequences the datapath through commands; depends on pmsp_pkg.
module pmsp_ctrl
  import pmsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  pmsp_sts_t sts,
  output pmsp_cmd_t cmd
);

  typedef enum logic [3:0] {
    IDLE, DECODE, PROD, BANK_CHK, DIV1, AVG, DIV2, BWRITE, SCAN, LEAVE, DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = state == IDLE;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.cap = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        state_next = DONE;
        case (sts.action)
          ACT_BANK: cmd.bank_upd = 1'b1;
          ACT_PIM:  cmd.pim_upd = 1'b1;
          ACT_UPDATE: begin
            if (sts.mode) begin
              if (sts.over) begin
                cmd.set_len = 1'b1;
                state_next = PROD;
              end else begin
                state_next = LEAVE;
              end
            end else if (sts.pim) begin
              state_next = SCAN;
            end
          end
          default: state_next = DONE;
        endcase
      end
      PROD: begin
        cmd.set_prod = 1'b1;
        state_next = BANK_CHK;
      end
      BANK_CHK: begin
        if (sts.cnt_zero) begin
          cmd.avg_dflt = 1'b1;
          state_next = AVG;
        end else begin
          cmd.div_start = 1'b1;
          state_next = DIV1;
        end
      end
      DIV1: begin
        if (sts.div_done) begin
          cmd.avg_from_div = 1'b1;
          state_next = AVG;
        end
      end
      AVG: begin
        if (sts.avg_zero) begin
          state_next = BWRITE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = 1'b1;
          state_next = DIV2;
        end
      end
      DIV2: begin
        if (sts.div_done) state_next = BWRITE;
      end
      BWRITE: begin
        cmd.bud_write = 1'b1;
        if (sts.last) begin
          state_next = LEAVE;
        end else begin
          cmd.widx_inc = 1'b1;
          state_next = BANK_CHK;
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (sts.last) begin
          cmd.go_pim = sts.exceeded || !sts.normal_waiting;
          state_next = DONE;
        end else begin
          cmd.widx_inc = 1'b1;
        end
      end
      LEAVE: begin
        cmd.go_normal = sts.normal_waiting;
        state_next = DONE;
      end
      DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hdl/pim_mode_switch_policy.sv */
// Top level of the PIM mode switch policy block.
// Depends on pmsp_pkg, pmsp_ctrl, pmsp_dp and pmsp_div.
//
// This block decides whether a memory controller serves processing-in-memory
// requests or normal reads and writes. Each input beat is one event, its kind
// given on s_tuser: a mode update, a bank schedule outcome or a PIM schedule
// outcome. Each input beat yields exactly one output beat carrying the mode
// after the event and whether the event switched mode. Bank and PIM outcomes
// and updates that only look at the mode go from decode straight to the
// done step; an update in PIM mode that closes no batch passes a leave step.
// An update in normal mode with PIM work waiting scans the bank counters one
// bank a cycle. An update that closes a PIM batch recomputes every bank's
// budget through one shared 40-step serial divider, used up to twice per
// bank: once for its measured average when it has requests, once to divide
// by that average when it is not zero. One item is in work at a time; the
// result sits in an output register, so the next item is accepted while the
// last result waits. Configuration registers sit at byte addresses 0, 4 and
// 8 and must be written only while the block is idle; the block itself does
// not enforce this.
module pim_mode_switch_policy
  import pmsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: cycle[31:0], reads_pending, writes_pending, pim_pending,
  // pim_front_row[15:0], bank[3:0], granted, granted_row[15:0].
  input  logic [71:0] s_tdata,
  // Fields from bit 0: action[1:0].
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: mode, to_pim, to_normal, then zero padding.
  output logic [7:0]  m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pmsp_cmd_t cmd;
  pmsp_sts_t sts;

  logic       write_queue_on;
  logic [7:0] default_latency;
  logic [7:0] max_slowdown;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  // Register file; writes complete on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_queue_on <= 1'b0;
      default_latency <= 8'd4;
      max_slowdown <= 8'd2;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (reg_idx)
        REG_WRITE_QUEUE_ON:  write_queue_on <= pwdata[0];
        REG_DEFAULT_LATENCY: default_latency <= pwdata[7:0];
        REG_MAX_SLOWDOWN:    max_slowdown <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WRITE_QUEUE_ON:  prdata = 32'(write_queue_on);
      REG_DEFAULT_LATENCY: prdata = 32'(default_latency);
      REG_MAX_SLOWDOWN:    prdata = 32'(max_slowdown);
      default:             prdata = 32'd0;
    endcase
  end

  pmsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pmsp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (s_tuser),
    .in_data         (s_tdata),
    .write_queue_on  (write_queue_on),
    .default_latency (default_latency),
    .max_slowdown    (max_slowdown),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_data        (m_tdata)
  );

endmodule

/* hdl/pmsp_chk.sv */
// Port-level checker for the PIM mode switch policy, bound to the top level.
// Depends only on the top level's ports.
module pmsp_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       pready
);

  // A waiting result beat is held until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // One item at a time: right after acceptance the input side is closed.
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  // A switch to PIM shows PIM mode, a switch to normal shows normal mode.
  a_to_pim: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0] && !m_tdata[2])
    else $error("to_pim beat inconsistent with mode");

  a_to_norm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1])
    else $error("to_normal beat inconsistent with mode");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind pim_mode_switch_policy pmsp_chk u_pmsp_chk (.*);
